/* sv/i2cmrt_pkg.sv */
package i2cmrt_pkg;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned ADDR_W    = 7;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TIMEOUT_W = 6;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd3;

    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 6'd50;
    localparam logic                 READ_BIT          = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] wr_data;
        logic              sda_sample;
    } req_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              need_byte;
        logic              rd_valid;
        logic [BYTE_W-1:0] rd_data;
        logic              rd_last;
        logic              done_res;
        logic              status;
    } res_t;

endpackage

/* sv/i2cmrt_if.sv */
interface i2cmrt_req_if
    import i2cmrt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] dev_addr;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] length;
    logic [BYTE_W-1:0] wr_data;
    logic              sda_sample;

    modport source (
        output valid, op, dev_addr, reg_addr, length, wr_data, sda_sample,
        input  ready
    );
    modport sink (
        input  valid, op, dev_addr, reg_addr, length, wr_data, sda_sample,
        output ready
    );
endinterface

interface i2cmrt_res_if
    import i2cmrt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              need_byte;
    logic              rd_valid;
    logic [BYTE_W-1:0] rd_data;
    logic              rd_last;
    logic              done_res;
    logic              status;

    modport source (
        output valid, scl_level, sda_level, busy_res, need_byte, rd_valid, rd_data,
               rd_last, done_res, status,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, busy_res, need_byte, rd_valid, rd_data,
               rd_last, done_res, status,
        output ready
    );
endinterface

/* sv/i2c_master_register_transfer.sv */
// A request is held in the input register, and its result then in the result register, before it is offered.
// Throughput: one request per cycle while results are taken (res.ready); each request is one bus timing slot.
// The result register decouples the sides: a new request is taken into an empty input register while a result waits.
// Reset (rst_n low, asynchronous): bus controller idle, both registers empty,
// ack_timeout back to 50.
module i2c_master_register_transfer
    import i2cmrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TIMEOUT_W-1:0] cfg_data,
    i2cmrt_req_if.sink           req,
    i2cmrt_res_if.source         res
);

    logic [TIMEOUT_W-1:0] ack_timeout_reg;
    logic                 in_valid_reg;
    req_t                 in_req_reg;
    logic                 out_valid_reg;
    res_t                 out_res_reg;
    res_t                 step_res;
    logic                 out_free;
    logic                 advance;

    assign out_free  = !out_valid_reg || res.ready;
    assign advance   = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            ack_timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_req_reg <= '{op: req.op, dev_addr: req.dev_addr, reg_addr: req.reg_addr,
                            length: req.length, wr_data: req.wr_data,
                            sda_sample: req.sda_sample};
        end
    end

    i2cmrt_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .ack_timeout (ack_timeout_reg),
        .req         (in_req_reg),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.scl_level = out_res_reg.scl_level;
    assign res.sda_level = out_res_reg.sda_level;
    assign res.busy_res  = out_res_reg.busy_res;
    assign res.need_byte = out_res_reg.need_byte;
    assign res.rd_valid  = out_res_reg.rd_valid;
    assign res.rd_data   = out_res_reg.rd_data;
    assign res.rd_last   = out_res_reg.rd_last;
    assign res.done_res  = out_res_reg.done_res;
    assign res.status    = out_res_reg.status;

endmodule

/* sv/i2cmrt_core.sv */
module i2cmrt_core
    import i2cmrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [TIMEOUT_W-1:0] ack_timeout,
    input  req_t                 req,
    output res_t                 res
);

    typedef enum logic [16:0] {
        PH_IDLE  = 17'b0_0000_0000_0000_0001,
        PH_ST_A  = 17'b0_0000_0000_0000_0010,
        PH_ST_B  = 17'b0_0000_0000_0000_0100,
        PH_ST_C  = 17'b0_0000_0000_0000_1000,
        PH_TX_LO = 17'b0_0000_0000_0001_0000,
        PH_TX_HI = 17'b0_0000_0000_0010_0000,
        PH_AK_LO = 17'b0_0000_0000_0100_0000,
        PH_AK_HI = 17'b0_0000_0000_1000_0000,
        PH_WAIT  = 17'b0_0000_0001_0000_0000,
        PH_RS_A  = 17'b0_0000_0010_0000_0000,
        PH_RX_LO = 17'b0_0000_0100_0000_0000,
        PH_RX_HI = 17'b0_0000_1000_0000_0000,
        PH_MA_LO = 17'b0_0001_0000_0000_0000,
        PH_MA_HI = 17'b0_0010_0000_0000_0000,
        PH_SP_A  = 17'b0_0100_0000_0000_0000,
        PH_SP_B  = 17'b0_1000_0000_0000_0000,
        PH_SP_C  = 17'b1_0000_0000_0000_0000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ADDR = 2'd0,
        KIND_REG  = 2'd1,
        KIND_DATA = 2'd2
    } kind_t;

    typedef struct packed {
        phase_t               phase;
        logic [3:0]           bit_index;
        logic [BYTE_W-1:0]    shift_byte;
        logic [BYTE_W-1:0]    bytes_left;
        logic [TIMEOUT_W-1:0] ack_wait;
        logic [ADDR_W-1:0]    slave_addr;
        logic [BYTE_W-1:0]    register_addr;
        logic                 is_read;
        logic                 in_read_phase;
        kind_t                byte_kind;
        logic                 failed;
    } state_t;

    state_t st_reg;
    state_t st_next;

    always_comb
    begin
        state_t            cur;
        logic [3:0]        bit_inc;
        logic [BYTE_W-1:0] bytes_dec;
        logic [BYTE_W-1:0] rx_byte;

        cur           = st_reg;
        res           = '0;
        res.scl_level = 1'b1;
        res.sda_level = 1'b1;
        res.busy_res  = 1'b1;

        if (cur.phase == PH_IDLE && (req.op == OP_WRITE || req.op == OP_READ))
        begin
            cur.slave_addr    = req.dev_addr;
            cur.register_addr = req.reg_addr;
            cur.bytes_left    = req.length;
            cur.is_read       = (req.op == OP_READ);
            cur.in_read_phase = 1'b0;
            cur.failed        = 1'b0;
            cur.phase         = PH_ST_A;
        end
        else if (cur.phase == PH_WAIT && req.op == OP_BYTE)
        begin
            cur.shift_byte = req.wr_data;
            cur.bit_index  = '0;
            cur.byte_kind  = KIND_DATA;
            cur.phase      = PH_TX_LO;
        end

        st_next   = cur;
        bit_inc   = cur.bit_index + 4'd1;
        bytes_dec = cur.bytes_left - 8'd1;
        rx_byte   = {cur.shift_byte[BYTE_W-2:0], req.sda_sample};

        unique case (cur.phase)
            PH_IDLE:
            begin
                res.busy_res = 1'b0;
            end
            PH_ST_A:
            begin
                st_next.phase = PH_ST_B;
            end
            PH_ST_B:
            begin
                res.sda_level = 1'b0;
                st_next.phase = PH_ST_C;
            end
            PH_ST_C:
            begin
                res.scl_level      = 1'b0;
                res.sda_level      = 1'b0;
                st_next.shift_byte = {cur.slave_addr, cur.in_read_phase & READ_BIT};
                st_next.bit_index  = '0;
                st_next.byte_kind  = KIND_ADDR;
                st_next.phase      = PH_TX_LO;
            end
            PH_TX_LO:
            begin
                res.scl_level = 1'b0;
                res.sda_level = cur.shift_byte[BYTE_W-1];
                st_next.phase = PH_TX_HI;
            end
            PH_TX_HI:
            begin
                res.sda_level      = cur.shift_byte[BYTE_W-1];
                st_next.shift_byte = {cur.shift_byte[BYTE_W-2:0], 1'b0};
                if (bit_inc[3])
                begin
                    st_next.bit_index = '0;
                    st_next.ack_wait  = '0;
                    st_next.phase     = PH_AK_LO;
                end
                else
                begin
                    st_next.bit_index = bit_inc;
                    st_next.phase     = PH_TX_LO;
                end
            end
            PH_AK_LO:
            begin
                res.scl_level = 1'b0;
                st_next.phase = PH_AK_HI;
            end
            PH_AK_HI:
            begin
                if (!req.sda_sample)
                begin
                    if (cur.byte_kind == KIND_ADDR && !cur.in_read_phase)
                    begin
                        st_next.shift_byte = cur.register_addr;
                        st_next.bit_index  = '0;
                        st_next.byte_kind  = KIND_REG;
                        st_next.phase      = PH_TX_LO;
                    end
                    else if (cur.byte_kind == KIND_REG)
                    begin
                        if (cur.is_read)
                        begin
                            st_next.in_read_phase = 1'b1;
                            st_next.phase         = PH_RS_A;
                        end
                        else if (cur.bytes_left == '0)
                        begin
                            st_next.failed = 1'b0;
                            st_next.phase  = PH_SP_A;
                        end
                        else
                        begin
                            st_next.phase = PH_WAIT;
                        end
                    end
                    else if (cur.byte_kind == KIND_DATA)
                    begin
                        st_next.bytes_left = bytes_dec;
                        st_next.failed     = 1'b0;
                        st_next.phase      = (bytes_dec == '0) ? PH_SP_A : PH_WAIT;
                    end
                    else if (cur.bytes_left == '0)
                    begin
                        st_next.failed = 1'b0;
                        st_next.phase  = PH_SP_A;
                    end
                    else
                    begin
                        st_next.shift_byte = '0;
                        st_next.bit_index  = '0;
                        st_next.phase      = PH_RX_LO;
                    end
                end
                else if (cur.ack_wait >= ack_timeout)
                begin
                    st_next.failed = 1'b1;
                    st_next.phase  = PH_SP_A;
                end
                else
                begin
                    st_next.ack_wait = cur.ack_wait + 6'd1;
                end
            end
            PH_WAIT:
            begin
                res.scl_level = 1'b0;
            end
            PH_RS_A:
            begin
                res.scl_level = 1'b0;
                st_next.phase = PH_ST_A;
            end
            PH_RX_LO:
            begin
                res.scl_level = 1'b0;
                st_next.phase = PH_RX_HI;
            end
            PH_RX_HI:
            begin
                st_next.shift_byte = rx_byte;
                if (bit_inc[3])
                begin
                    st_next.bit_index = '0;
                    res.rd_valid      = 1'b1;
                    res.rd_data       = rx_byte;
                    res.rd_last       = (cur.bytes_left == 8'd1);
                    st_next.phase     = PH_MA_LO;
                end
                else
                begin
                    st_next.bit_index = bit_inc;
                    st_next.phase     = PH_RX_LO;
                end
            end
            PH_MA_LO:
            begin
                res.scl_level = 1'b0;
                res.sda_level = (cur.bytes_left == 8'd1);
                st_next.phase = PH_MA_HI;
            end
            PH_MA_HI:
            begin
                res.sda_level      = (cur.bytes_left == 8'd1);
                st_next.bytes_left = bytes_dec;
                if (bytes_dec == '0)
                begin
                    st_next.failed = 1'b0;
                    st_next.phase  = PH_SP_A;
                end
                else
                begin
                    st_next.shift_byte = '0;
                    st_next.phase      = PH_RX_LO;
                end
            end
            PH_SP_A:
            begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
                st_next.phase = PH_SP_B;
            end
            PH_SP_B:
            begin
                res.sda_level = 1'b0;
                st_next.phase = PH_SP_C;
            end
            default:
            begin
                res.done_res          = 1'b1;
                res.status            = cur.failed;
                st_next.failed        = 1'b0;
                st_next.in_read_phase = 1'b0;
                st_next.phase         = PH_IDLE;
            end
        endcase

        res.need_byte = (st_next.phase == PH_WAIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: PH_IDLE, byte_kind: KIND_ADDR, default: '0};
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

endmodule
